// ----- design/mcu_pkg.sv -----
package mcu_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int COORD_FRAC_BITS = 12;
    localparam int OUT_FRAC_BITS   = 16;

    localparam int DIFF_W  = COORD_WIDTH;
    localparam int SQ_W    = 2 * DIFF_W + 1;
    localparam int SIDE_W  = (SQ_W + 1) / 2;
    localparam int SRT_W   = 2 * SIDE_W;
    localparam int PER_W   = SIDE_W + 2;
    localparam int MAG_W   = PER_W;
    localparam int P1_W    = 2 * MAG_W;
    localparam int P2_W    = 3 * MAG_W;
    localparam int RAD_W   = 4 * MAG_W;
    localparam int AREA_W  = (RAD_W + 1) / 2;
    localparam int ART_W   = 2 * AREA_W;
    localparam int DEN_W   = 3 * SIDE_W;
    localparam int Q_W     = 32;
    localparam int DIV_W   = DEN_W + Q_W;
    localparam int SHIFT   = COORD_FRAC_BITS + OUT_FRAC_BITS;
    localparam int IN_W    = ((6 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_W   = ((Q_W + 7) / 8) * 8;
    localparam int USER_W  = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [DIFF_W-1:0]   t_diff;
    typedef logic [SQ_W-1:0]     t_sq;
    typedef logic [SIDE_W-1:0]   t_side;
    typedef logic [SRT_W-1:0]    t_side_rem;
    typedef logic [PER_W-1:0]    t_per;
    typedef logic [P1_W-1:0]     t_p1;
    typedef logic [P2_W-1:0]     t_p2;
    typedef logic [2*MAG_W-1:0]  t_prod;
    typedef logic [2*SIDE_W-1:0] t_dprod;
    typedef logic [RAD_W-1:0]    t_rad;
    typedef logic [AREA_W-1:0]   t_area;
    typedef logic [ART_W-1:0]    t_area_rem;
    typedef logic [DEN_W-1:0]    t_den;
    typedef logic [DIV_W-1:0]    t_div;
    typedef logic [Q_W-1:0]      t_quot;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord cx;
        t_coord cy;
    } t_points;

    typedef struct packed {
        t_side ab;
        t_side ac;
        t_side bc;
    } t_sides;

    typedef struct packed {
        t_rad rad;
        t_den den;
        logic degen;
    } t_rad_item;

    typedef struct packed {
        t_area area;
        t_den  den;
        logic  degen;
    } t_div_item;

    typedef struct packed {
        t_quot curvature;
        logic  degenerate;
        logic  saturated;
    } t_result;

endpackage

// ----- design/mcu_side_chain.sv -----
module mcu_side_chain (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  mcu_pkg::t_points i_pts,
    output logic            o_valid,
    output mcu_pkg::t_sides o_sides
);

    mcu_pkg::t_diff     n_dx [3];
    mcu_pkg::t_diff     n_dy [3];
    mcu_pkg::t_diff     r_dx [3];
    mcu_pkg::t_diff     r_dy [3];
    mcu_pkg::t_sq       n_sq [3];
    mcu_pkg::t_sq       r_sq [3];
    logic               r_v0;
    logic               r_v1;

    mcu_pkg::t_side_rem c_rem  [mcu_pkg::SIDE_W][3];
    mcu_pkg::t_side     c_root [mcu_pkg::SIDE_W][3];
    mcu_pkg::t_side_rem n_rem  [mcu_pkg::SIDE_W][3];
    mcu_pkg::t_side     n_root [mcu_pkg::SIDE_W][3];
    mcu_pkg::t_side_rem r_rem  [mcu_pkg::SIDE_W][3];
    mcu_pkg::t_side     r_root [mcu_pkg::SIDE_W][3];
    mcu_pkg::t_side_rem trial  [mcu_pkg::SIDE_W][3];
    logic               r_v [mcu_pkg::SIDE_W];

    function automatic mcu_pkg::t_diff absd(input mcu_pkg::t_coord a, input mcu_pkg::t_coord b);
        logic signed [mcu_pkg::COORD_WIDTH:0] d;
        d = {a[mcu_pkg::COORD_WIDTH-1], a} - {b[mcu_pkg::COORD_WIDTH-1], b};
        absd = d[mcu_pkg::COORD_WIDTH] ? ~d[mcu_pkg::COORD_WIDTH-1:0] + 1'b1
                                       : d[mcu_pkg::COORD_WIDTH-1:0];
    endfunction

    always_comb begin
        n_dx[0] = absd(i_pts.ax, i_pts.bx);
        n_dy[0] = absd(i_pts.ay, i_pts.by);
        n_dx[1] = absd(i_pts.ax, i_pts.cx);
        n_dy[1] = absd(i_pts.ay, i_pts.cy);
        n_dx[2] = absd(i_pts.bx, i_pts.cx);
        n_dy[2] = absd(i_pts.by, i_pts.cy);
        for (int l = 0; l < 3; l++) begin
            n_sq[l] = mcu_pkg::t_sq'(r_dx[l] * r_dx[l]) + mcu_pkg::t_sq'(r_dy[l] * r_dy[l]);
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            c_rem[0][l]  = mcu_pkg::t_side_rem'(r_sq[l]);
            c_root[0][l] = '0;
        end
        for (int k = 1; k < mcu_pkg::SIDE_W; k++) begin
            for (int l = 0; l < 3; l++) begin
                c_rem[k][l]  = r_rem[k-1][l];
                c_root[k][l] = r_root[k-1][l];
            end
        end
        for (int k = 0; k < mcu_pkg::SIDE_W; k++) begin
            for (int l = 0; l < 3; l++) begin
                trial[k][l] = (mcu_pkg::t_side_rem'(c_root[k][l]) << (mcu_pkg::SIDE_W - k))
                            | (mcu_pkg::t_side_rem'(1) << (2 * (mcu_pkg::SIDE_W - 1 - k)));
                if (c_rem[k][l] >= trial[k][l]) begin
                    n_rem[k][l]  = c_rem[k][l] - trial[k][l];
                    n_root[k][l] = c_root[k][l] | (mcu_pkg::t_side'(1) << (mcu_pkg::SIDE_W - 1 - k));
                end else begin
                    n_rem[k][l]  = c_rem[k][l];
                    n_root[k][l] = c_root[k][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            for (int k = 0; k < mcu_pkg::SIDE_W; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v[0] <= r_v1;
            for (int k = 1; k < mcu_pkg::SIDE_W; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_dx[l] <= n_dx[l];
                r_dy[l] <= n_dy[l];
                r_sq[l] <= n_sq[l];
            end
            for (int k = 0; k < mcu_pkg::SIDE_W; k++) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[k][l]  <= n_rem[k][l];
                    r_root[k][l] <= n_root[k][l];
                end
            end
        end
    end

    assign o_valid  = r_v[mcu_pkg::SIDE_W-1];
    assign o_sides.ab = r_root[mcu_pkg::SIDE_W-1][0];
    assign o_sides.ac = r_root[mcu_pkg::SIDE_W-1][1];
    assign o_sides.bc = r_root[mcu_pkg::SIDE_W-1][2];

endmodule

// ----- design/mcu_rad_mult.sv -----
module mcu_rad_mult (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  mcu_pkg::t_sides    i_sides,
    output logic               o_valid,
    output mcu_pkg::t_rad_item o_item
);

    mcu_pkg::t_per  n_per;
    mcu_pkg::t_per  n_mag [3];
    mcu_pkg::t_per  two   [3];
    mcu_pkg::t_side side  [3];
    logic           n_zero;
    logic           n_neg;
    logic           n_dg;

    logic [5:0]     r_v;
    mcu_pkg::t_per  r0_per;
    mcu_pkg::t_per  r0_mag [3];
    mcu_pkg::t_side r0_side [3];
    logic           r0_dg;
    mcu_pkg::t_p1   r1_p1;
    mcu_pkg::t_dprod r1_d1;
    mcu_pkg::t_per  r1_mag1;
    mcu_pkg::t_per  r1_mag2;
    mcu_pkg::t_side r1_bc;
    logic           r1_dg;
    mcu_pkg::t_prod r2_pa;
    mcu_pkg::t_prod r2_pb;
    mcu_pkg::t_dprod r2_da;
    mcu_pkg::t_dprod r2_db;
    mcu_pkg::t_per  r2_mag2;
    logic           r2_dg;
    mcu_pkg::t_p2   r3_p2;
    mcu_pkg::t_den  r3_den;
    mcu_pkg::t_per  r3_mag2;
    logic           r3_dg;
    mcu_pkg::t_prod r4_q [3];
    mcu_pkg::t_den  r4_den;
    logic           r4_dg;
    mcu_pkg::t_rad  r5_rad;
    mcu_pkg::t_den  r5_den;
    logic           r5_dg;

    always_comb begin
        side[0] = i_sides.ab;
        side[1] = i_sides.ac;
        side[2] = i_sides.bc;
        n_per = mcu_pkg::t_per'(i_sides.ab) + mcu_pkg::t_per'(i_sides.ac)
              + mcu_pkg::t_per'(i_sides.bc);
        n_zero = 1'b0;
        n_neg  = 1'b0;
        for (int l = 0; l < 3; l++) begin
            two[l] = mcu_pkg::t_per'({side[l], 1'b0});
            if (n_per > two[l]) begin
                n_mag[l] = n_per - two[l];
            end else if (n_per == two[l]) begin
                n_mag[l] = '0;
                n_zero   = 1'b1;
            end else begin
                n_mag[l] = two[l] - n_per;
                n_neg    = ~n_neg;
            end
        end
        n_dg = n_zero || n_neg || (n_per == '0) || (i_sides.ab == '0)
            || (i_sides.ac == '0) || (i_sides.bc == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_per <= n_per;
            for (int l = 0; l < 3; l++) begin
                r0_mag[l]  <= n_mag[l];
                r0_side[l] <= side[l];
            end
            r0_dg <= n_dg;

            r1_p1   <= r0_per * r0_mag[0];
            r1_d1   <= r0_side[0] * r0_side[1];
            r1_mag1 <= r0_mag[1];
            r1_mag2 <= r0_mag[2];
            r1_bc   <= r0_side[2];
            r1_dg   <= r0_dg;

            r2_pa   <= r1_p1[mcu_pkg::MAG_W-1:0] * r1_mag1;
            r2_pb   <= r1_p1[mcu_pkg::P1_W-1:mcu_pkg::MAG_W] * r1_mag1;
            r2_da   <= r1_d1[mcu_pkg::SIDE_W-1:0] * r1_bc;
            r2_db   <= r1_d1[2*mcu_pkg::SIDE_W-1:mcu_pkg::SIDE_W] * r1_bc;
            r2_mag2 <= r1_mag2;
            r2_dg   <= r1_dg;

            r3_p2   <= mcu_pkg::t_p2'(r2_pa) + (mcu_pkg::t_p2'(r2_pb) << mcu_pkg::MAG_W);
            r3_den  <= mcu_pkg::t_den'(r2_da) + (mcu_pkg::t_den'(r2_db) << mcu_pkg::SIDE_W);
            r3_mag2 <= r2_mag2;
            r3_dg   <= r2_dg;

            r4_q[0] <= r3_p2[mcu_pkg::MAG_W-1:0] * r3_mag2;
            r4_q[1] <= r3_p2[2*mcu_pkg::MAG_W-1:mcu_pkg::MAG_W] * r3_mag2;
            r4_q[2] <= r3_p2[3*mcu_pkg::MAG_W-1:2*mcu_pkg::MAG_W] * r3_mag2;
            r4_den  <= r3_den;
            r4_dg   <= r3_dg;

            r5_rad  <= mcu_pkg::t_rad'(r4_q[0])
                     + (mcu_pkg::t_rad'(r4_q[1]) << mcu_pkg::MAG_W)
                     + (mcu_pkg::t_rad'(r4_q[2]) << (2 * mcu_pkg::MAG_W));
            r5_den  <= r4_den;
            r5_dg   <= r4_dg;
        end
    end

    assign o_valid      = r_v[5];
    assign o_item.rad   = r5_rad;
    assign o_item.den   = r5_den;
    assign o_item.degen = r5_dg;

endmodule

// ----- design/mcu_area_chain.sv -----
module mcu_area_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  mcu_pkg::t_rad_item i_item,
    output logic               o_valid,
    output mcu_pkg::t_div_item o_item
);

    mcu_pkg::t_area_rem c_rem  [mcu_pkg::AREA_W];
    mcu_pkg::t_area     c_root [mcu_pkg::AREA_W];
    mcu_pkg::t_den      c_den  [mcu_pkg::AREA_W];
    logic               c_dg   [mcu_pkg::AREA_W];
    mcu_pkg::t_area_rem trial  [mcu_pkg::AREA_W];
    mcu_pkg::t_area_rem n_rem  [mcu_pkg::AREA_W];
    mcu_pkg::t_area     n_root [mcu_pkg::AREA_W];
    mcu_pkg::t_area_rem r_rem  [mcu_pkg::AREA_W];
    mcu_pkg::t_area     r_root [mcu_pkg::AREA_W];
    mcu_pkg::t_den      r_den  [mcu_pkg::AREA_W];
    logic               r_dg   [mcu_pkg::AREA_W];
    logic               r_v    [mcu_pkg::AREA_W];

    always_comb begin
        c_rem[0]  = mcu_pkg::t_area_rem'(i_item.rad);
        c_root[0] = '0;
        c_den[0]  = i_item.den;
        c_dg[0]   = i_item.degen;
        for (int k = 1; k < mcu_pkg::AREA_W; k++) begin
            c_rem[k]  = r_rem[k-1];
            c_root[k] = r_root[k-1];
            c_den[k]  = r_den[k-1];
            c_dg[k]   = r_dg[k-1];
        end
        for (int k = 0; k < mcu_pkg::AREA_W; k++) begin
            trial[k] = (mcu_pkg::t_area_rem'(c_root[k]) << (mcu_pkg::AREA_W - k))
                     | (mcu_pkg::t_area_rem'(1) << (2 * (mcu_pkg::AREA_W - 1 - k)));
            if (c_rem[k] >= trial[k]) begin
                n_rem[k]  = c_rem[k] - trial[k];
                n_root[k] = c_root[k] | (mcu_pkg::t_area'(1) << (mcu_pkg::AREA_W - 1 - k));
            end else begin
                n_rem[k]  = c_rem[k];
                n_root[k] = c_root[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mcu_pkg::AREA_W; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < mcu_pkg::AREA_W; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < mcu_pkg::AREA_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_den[k]  <= c_den[k];
                r_dg[k]   <= c_dg[k];
            end
        end
    end

    assign o_valid      = r_v[mcu_pkg::AREA_W-1];
    assign o_item.area  = r_root[mcu_pkg::AREA_W-1];
    assign o_item.den   = r_den[mcu_pkg::AREA_W-1];
    assign o_item.degen = r_dg[mcu_pkg::AREA_W-1];

endmodule

// ----- design/mcu_div_chain.sv -----
module mcu_div_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  mcu_pkg::t_div_item i_item,
    output logic               o_valid,
    output mcu_pkg::t_result   o_res
);

    mcu_pkg::t_div  n_num;
    logic           n_sat;
    logic           r_pv;
    mcu_pkg::t_div  r_pnum;
    mcu_pkg::t_den  r_pden;
    logic           r_pdg;
    logic           r_psat;

    mcu_pkg::t_div  c_rem [mcu_pkg::Q_W];
    mcu_pkg::t_quot c_q   [mcu_pkg::Q_W];
    mcu_pkg::t_den  c_den [mcu_pkg::Q_W];
    logic           c_dg  [mcu_pkg::Q_W];
    logic           c_sat [mcu_pkg::Q_W];
    mcu_pkg::t_div  dsh   [mcu_pkg::Q_W];
    mcu_pkg::t_div  n_rem [mcu_pkg::Q_W];
    mcu_pkg::t_quot n_q   [mcu_pkg::Q_W];
    mcu_pkg::t_div  r_rem [mcu_pkg::Q_W];
    mcu_pkg::t_quot r_q   [mcu_pkg::Q_W];
    mcu_pkg::t_den  r_den [mcu_pkg::Q_W];
    logic           r_dg  [mcu_pkg::Q_W];
    logic           r_sat [mcu_pkg::Q_W];
    logic           r_v   [mcu_pkg::Q_W];

    always_comb begin
        n_num = mcu_pkg::t_div'(i_item.area) << mcu_pkg::SHIFT;
        n_sat = !i_item.degen && ((mcu_pkg::t_div'(i_item.den) << mcu_pkg::Q_W) <= n_num);
    end

    always_comb begin
        c_rem[0] = r_pnum;
        c_q[0]   = '0;
        c_den[0] = r_pden;
        c_dg[0]  = r_pdg;
        c_sat[0] = r_psat;
        for (int k = 1; k < mcu_pkg::Q_W; k++) begin
            c_rem[k] = r_rem[k-1];
            c_q[k]   = r_q[k-1];
            c_den[k] = r_den[k-1];
            c_dg[k]  = r_dg[k-1];
            c_sat[k] = r_sat[k-1];
        end
        for (int k = 0; k < mcu_pkg::Q_W; k++) begin
            dsh[k] = mcu_pkg::t_div'(c_den[k]) << (mcu_pkg::Q_W - 1 - k);
            if (dsh[k] <= c_rem[k]) begin
                n_rem[k] = c_rem[k] - dsh[k];
                n_q[k]   = c_q[k] | (mcu_pkg::t_quot'(1) << (mcu_pkg::Q_W - 1 - k));
            end else begin
                n_rem[k] = c_rem[k];
                n_q[k]   = c_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            for (int k = 0; k < mcu_pkg::Q_W; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_pv   <= i_valid;
            r_v[0] <= r_pv;
            for (int k = 1; k < mcu_pkg::Q_W; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pnum <= n_num;
            r_pden <= i_item.den;
            r_pdg  <= i_item.degen;
            r_psat <= n_sat;
            for (int k = 0; k < mcu_pkg::Q_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= c_den[k];
                r_dg[k]  <= c_dg[k];
                r_sat[k] <= c_sat[k];
            end
        end
    end

    always_comb begin
        o_valid = r_v[mcu_pkg::Q_W-1];
        if (r_dg[mcu_pkg::Q_W-1]) begin
            o_res.curvature = '0;
        end else if (r_sat[mcu_pkg::Q_W-1]) begin
            o_res.curvature = '1;
        end else begin
            o_res.curvature = r_q[mcu_pkg::Q_W-1];
        end
        o_res.degenerate = r_dg[mcu_pkg::Q_W-1];
        o_res.saturated  = r_sat[mcu_pkg::Q_W-1];
    end

endmodule

// ----- design/menger_curvature_unit_core.sv -----
// Menger curvature of three points, one triple accepted per clock cycle unless the chain
// holds. The datapath is a chain of cells: three lanes of bit-per-cell square roots for the
// side lengths (a difference stage and a square stage, then 25 cells), a six-stage Heron
// radicand and side-product multiplier, a bit-per-cell square root for the area (54 cells)
// and a bit-per-cell restoring divider for the quotient (a prescale stage, then 32 cells). A
// result that is not taken sits in the output register and a skid register, and the whole
// chain holds only once both are full. Points whose radicand is not positive give curvature
// 0 with the degenerate flag; a quotient above the 32-bit range gives all ones with the
// saturated flag.
module menger_curvature_unit_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y
    input  logic [mcu_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // curvature
    output logic [mcu_pkg::OUT_W-1:0]  m_axis_tdata,
    // degenerate, saturated
    output logic [mcu_pkg::USER_W-1:0] m_axis_tuser
);

    logic               en;
    mcu_pkg::t_points   pts;
    logic               side_v;
    mcu_pkg::t_sides    sides;
    logic               rad_v;
    mcu_pkg::t_rad_item rad_item;
    logic               area_v;
    mcu_pkg::t_div_item div_item;
    logic               res_v;
    mcu_pkg::t_result   res;
    logic               pipe_out_v;
    logic               r_out_v;
    logic               r_skid_v;
    mcu_pkg::t_result   r_out;
    mcu_pkg::t_result   r_skid;

    assign en            = !r_skid_v;
    assign s_axis_tready = en;
    assign pipe_out_v    = res_v && en;

    assign pts.ax = s_axis_tdata[1*mcu_pkg::COORD_WIDTH-1:0];
    assign pts.ay = s_axis_tdata[2*mcu_pkg::COORD_WIDTH-1:1*mcu_pkg::COORD_WIDTH];
    assign pts.bx = s_axis_tdata[3*mcu_pkg::COORD_WIDTH-1:2*mcu_pkg::COORD_WIDTH];
    assign pts.by = s_axis_tdata[4*mcu_pkg::COORD_WIDTH-1:3*mcu_pkg::COORD_WIDTH];
    assign pts.cx = s_axis_tdata[5*mcu_pkg::COORD_WIDTH-1:4*mcu_pkg::COORD_WIDTH];
    assign pts.cy = s_axis_tdata[6*mcu_pkg::COORD_WIDTH-1:5*mcu_pkg::COORD_WIDTH];

    mcu_side_chain u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_pts   (pts),
        .o_valid (side_v),
        .o_sides (sides)
    );

    mcu_rad_mult u_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (side_v),
        .i_sides (sides),
        .o_valid (rad_v),
        .o_item  (rad_item)
    );

    mcu_area_chain u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rad_v),
        .i_item  (rad_item),
        .o_valid (area_v),
        .o_item  (div_item)
    );

    mcu_div_chain u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (area_v),
        .i_item  (div_item),
        .o_valid (res_v),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= pipe_out_v;
            end
        end else if (pipe_out_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || m_axis_tready) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (pipe_out_v) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = mcu_pkg::OUT_W'(r_out.curvature);
    assign m_axis_tuser  = {r_out.saturated, r_out.degenerate};

`ifndef ASSERT_OFF
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("degenerate and saturated both set");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (r_out.curvature == '0))
        else $error("degenerate result with nonzero curvature");
    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (r_out.curvature == '1))
        else $error("saturated result not clamped");
    a_skid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full while output register empty");
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !m_axis_tready))
        else $error("skid register filled without a stalled output");
`endif

endmodule
